// File: src/sector_volume_map_top_defines.svh
// Assertion macros for the sector volume map top level.
// Depends on a clk and arst_n in the scope of each use.
`ifndef SECTOR_VOLUME_MAP_TOP_DEFINES_SVH
`define SECTOR_VOLUME_MAP_TOP_DEFINES_SVH

// Check an implication on every clock edge outside reset.
`define SVM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a plain condition on every clock edge outside reset.
`define SVM_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`endif

// File: src/svm_pkg.sv
// Shared types, constants and codes of the sector volume map.
// No dependencies; used by every module of the block.
package svm_pkg;

	localparam int MAX_VOLUMES  = 8;
	localparam int ROUND_SHIFT  = 10;
	localparam int ROUND        = 1 << ROUND_SHIFT;
	localparam int IDX_W        = (MAX_VOLUMES > 1) ? $clog2(MAX_VOLUMES) : 1;
	localparam int CNT_W        = $clog2(MAX_VOLUMES + 1);
	localparam int OUT_IDX_W    = 3;
	localparam int SECTOR_SHIFT = 9;
	localparam logic [31:0] ROUND_MASK = 32'(ROUND - 1);

	localparam logic [2:0] CMD_ADD   = 3'd0;
	localparam logic [2:0] CMD_READ  = 3'd1;
	localparam logic [2:0] CMD_WRITE = 3'd2;
	localparam logic [2:0] CMD_SIZE  = 3'd3;
	localparam logic [2:0] CMD_CHECK = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_VOLUME = 3'd1;
	localparam logic [2:0] ST_CROSS     = 3'd2;
	localparam logic [2:0] ST_READ_ONLY = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] sector;
		logic [15:0] count;
		logic [31:0] raw_size;
		logic        want_read_only;
	} req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [OUT_IDX_W-1:0] volume_index;
		logic [31:0]          relative_sector;
		logic [31:0]          value;
	} rsp_t;

	typedef struct packed {
		logic        add;
		logic [31:0] size;
		logic        read_only;
	} tbl_wr_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             full;
		logic [31:0]      next_start;
		logic             hold_found;
		logic [IDX_W-1:0] hold_idx;
		logic [31:0]      hold_start;
		logic [31:0]      hold_size;
		logic             hold_ro;
		logic             start_found;
		logic [IDX_W-1:0] start_idx;
		logic [31:0]      start_size;
	} tbl_look_t;

endpackage

// File: src/svm_table.sv
// Volume table: start, size and read-only mark per entry, fill count, running end.
// Parallel holder and start lookup for one sector. Depends on svm_pkg.
module svm_table (
	input  logic               clk,
	input  logic               arst_n,
	input  svm_pkg::tbl_wr_t   wr,
	input  logic [31:0]        sector,
	output svm_pkg::tbl_look_t look
);
	import svm_pkg::*;

	logic [31:0]      start_q [MAX_VOLUMES];
	logic [31:0]      size_q  [MAX_VOLUMES];
	logic             ro_q    [MAX_VOLUMES];
	logic [CNT_W-1:0] count_q;
	logic [31:0]      next_start_q;
	logic [MAX_VOLUMES-1:0] hold_hit;
	logic [MAX_VOLUMES-1:0] start_hit;
	logic [IDX_W-1:0] hold_idx;
	logic [IDX_W-1:0] start_idx;

	always_ff @(posedge clk) begin
		if (wr.add) begin
			start_q[count_q[IDX_W-1:0]] <= next_start_q;
			size_q[count_q[IDX_W-1:0]]  <= wr.size;
			ro_q[count_q[IDX_W-1:0]]    <= wr.read_only;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			next_start_q <= '0;
		end else if (wr.add) begin
			count_q      <= count_q + CNT_W'(1);
			next_start_q <= next_start_q + wr.size;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_VOLUMES; i++) begin
			hold_hit[i]  = (CNT_W'(i) < count_q) && (start_q[i] <= sector)
				&& ((start_q[i] + size_q[i]) > sector);
			start_hit[i] = (CNT_W'(i) < count_q) && (start_q[i] == sector);
		end
		hold_idx  = '0;
		start_idx = '0;
		for (int i = MAX_VOLUMES - 1; i >= 0; i--) begin
			if (hold_hit[i]) begin
				hold_idx = IDX_W'(i);
			end
			if (start_hit[i]) begin
				start_idx = IDX_W'(i);
			end
		end
	end

	assign look.count       = count_q;
	assign look.full        = (count_q == CNT_W'(MAX_VOLUMES));
	assign look.next_start  = next_start_q;
	assign look.hold_found  = |hold_hit;
	assign look.hold_idx    = hold_idx;
	assign look.hold_start  = start_q[hold_idx];
	assign look.hold_size   = size_q[hold_idx];
	assign look.hold_ro     = ro_q[hold_idx];
	assign look.start_found = |start_hit;
	assign look.start_idx   = start_idx;
	assign look.start_size  = size_q[start_idx];

endmodule

// File: src/svm_resolve.sv
// Command decode and result forming from one table lookup.
// Produces the result item and the table append. Depends on svm_pkg.
module svm_resolve (
	input  svm_pkg::req_t      item,
	input  svm_pkg::tbl_look_t look,
	input  logic               write_bypass,
	output svm_pkg::rsp_t      rsp,
	output svm_pkg::tbl_wr_t   wr
);
	import svm_pkg::*;

	logic [31:0] size_r;
	logic [31:0] rel;
	logic [32:0] span;
	logic [31:0] hold_idx_w;
	logic [31:0] start_idx_w;
	logic [31:0] count_w;

	assign size_r      = item.raw_size & ~ROUND_MASK;
	assign rel         = item.sector - look.hold_start;
	assign span        = {1'b0, rel} + 33'(item.count);
	assign hold_idx_w  = 32'(look.hold_idx);
	assign start_idx_w = 32'(look.start_idx);
	assign count_w     = 32'(look.count);

	always_comb begin
		rsp = '0;
		wr  = '0;
		unique case (item.command)
			CMD_ADD: begin
				if (size_r == '0) begin
					rsp.status = ST_EMPTY;
				end else if (look.full) begin
					rsp.status = ST_FULL;
				end else begin
					rsp.status       = ST_OK;
					rsp.volume_index = count_w[OUT_IDX_W-1:0];
					rsp.value        = look.next_start;
					wr.add           = 1'b1;
					wr.size          = size_r;
					wr.read_only     = item.want_read_only & ~write_bypass;
				end
			end
			CMD_READ, CMD_WRITE: begin
				if (!look.hold_found) begin
					rsp.status = ST_NO_VOLUME;
				end else begin
					rsp.volume_index    = hold_idx_w[OUT_IDX_W-1:0];
					rsp.relative_sector = rel;
					if (item.command == CMD_WRITE && write_bypass) begin
						rsp.value = 32'(item.count) << SECTOR_SHIFT;
					end else if (item.command == CMD_WRITE && look.hold_ro) begin
						rsp.status = ST_READ_ONLY;
					end else if (span > {1'b0, look.hold_size}) begin
						rsp.status = ST_CROSS;
					end
				end
			end
			CMD_SIZE: begin
				if (!look.start_found) begin
					rsp.status = ST_NO_VOLUME;
				end else begin
					rsp.volume_index = start_idx_w[OUT_IDX_W-1:0];
					rsp.value        = look.start_size;
				end
			end
			CMD_CHECK: begin
				if (look.hold_found) begin
					rsp.volume_index = hold_idx_w[OUT_IDX_W-1:0];
				end
				rsp.value = 32'((look.hold_found && !look.hold_ro) || write_bypass);
			end
			default: begin
				rsp.status = ST_NO_VOLUME;
			end
		endcase
	end

endmodule

// File: src/sector_volume_map_top.sv
// An accepted item goes via the input register and the result register to rsp.
// Throughput: one item per cycle when rsp_stall is low; the input register and
// the result register each hold one item, and the table lookup plus decode fits
// between them. Reset clears the fill count, running end and the write bypass
// flag; table entries are written by add commands only. No clearing pass.
module sector_volume_map_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          req_valid,
	output logic          req_stall,
	input  svm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output svm_pkg::rsp_t rsp
);
	import svm_pkg::*;
	`include "sector_volume_map_top_defines.svh"

	logic      write_bypass_q;
	logic      valid_s1;
	req_t      req_s1;
	logic      valid_s2;
	rsp_t      rsp_s2;
	logic      adv_s2;
	logic      fire_s1;
	tbl_look_t look;
	tbl_wr_t   wr_raw;
	tbl_wr_t   wr;
	rsp_t      rsp_next;

	assign adv_s2    = !valid_s2 || !rsp_stall;
	assign fire_s1   = valid_s1 && adv_s2;
	assign req_stall = valid_s1 && !adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_bypass_q <= 1'b0;
		end else if (cfg_we) begin
			write_bypass_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (fire_s1) begin
			rsp_s2 <= rsp_next;
		end
	end

	svm_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.sector (req_s1.sector),
		.look   (look)
	);

	svm_resolve u_resolve (
		.item         (req_s1),
		.look         (look),
		.write_bypass (write_bypass_q),
		.rsp          (rsp_next),
		.wr           (wr_raw)
	);

	always_comb begin
		wr     = wr_raw;
		wr.add = wr_raw.add && fire_s1;
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	`SVM_ASSERT_ALWAYS(a_count_bound, look.count <= CNT_W'(MAX_VOLUMES), "fill count past table depth")
	`SVM_ASSERT_IMP(a_full_status, rsp_valid && rsp.status == ST_FULL, look.full, "full status while table has room")
	`SVM_ASSERT_IMP(a_s1_hold, req_stall, valid_s2 && rsp_stall, "input stage held without a blocked result")
	`SVM_ASSERT_IMP(a_add_needs_room, wr.add, !look.full, "append into a full table")

endmodule

// File: tb/sector_volume_map_top_test.sv
// Self-checking bench for sector_volume_map_top: directed and random requests, predicted
// results compared field by field on the rsp side, random idling on both channels.
// Depends on svm_pkg and the sector_volume_map_top RTL only.
module sector_volume_map_top_test;
	import svm_pkg::*;

	localparam logic [2:0] CMD_LAST = CMD_CHECK;
	localparam logic [2:0] CMD_TOP  = 3'h7;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  cfg_we = 1'b0;
	logic  cfg_wdata = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	req_t queued_requests [$];
	rsp_t owed_answers [$];

	bit [31:0] vol_start [MAX_VOLUMES];
	bit [31:0] vol_size [MAX_VOLUMES];
	bit        vol_ro [MAX_VOLUMES];
	int        vol_count = 0;
	bit [31:0] run_end = '0;
	bit        fake_on = 1'b0;

	int offer_gap_pct = 35;
	int stall_pct = 35;
	bit rsp_hold = 1'b0;
	bit squeeze_go = 1'b0;
	int mismatches = 0;

	sector_volume_map_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int holder_of(bit [31:0] s);
		for (int i = 0; i < vol_count; i++) begin
			if (vol_start[i] <= s && 32'(vol_start[i] + vol_size[i]) > s)
				return i;
		end
		return -1;
	endfunction

	function automatic int volume_at(bit [31:0] s);
		for (int i = 0; i < vol_count; i++) begin
			if (vol_start[i] == s)
				return i;
		end
		return -1;
	endfunction

	function automatic rsp_t map_request(req_t r);
		rsp_t o;
		bit [31:0] sz;
		int v;
		o = '0;
		case (r.command)
		CMD_ADD: begin
			sz = r.raw_size - r.raw_size % 32'(ROUND);
			if (sz == 0) begin
				o.status = ST_EMPTY;
			end else if (vol_count >= MAX_VOLUMES) begin
				o.status = ST_FULL;
			end else begin
				o.volume_index = 3'(vol_count);
				o.value = run_end;
				vol_start[vol_count] = run_end;
				vol_size[vol_count] = sz;
				vol_ro[vol_count] = r.want_read_only && !fake_on;
				run_end = run_end + sz;
				vol_count++;
			end
		end
		CMD_READ, CMD_WRITE: begin
			v = holder_of(r.sector);
			if (v < 0) begin
				o.status = ST_NO_VOLUME;
			end else begin
				o.volume_index = 3'(v);
				o.relative_sector = r.sector - vol_start[v];
				if (r.command == CMD_WRITE && fake_on)
					o.value = 32'(r.count) << SECTOR_SHIFT;
				else if (r.command == CMD_WRITE && vol_ro[v])
					o.status = ST_READ_ONLY;
				else if (33'(o.relative_sector) + 33'(r.count) > 33'(vol_size[v]))
					o.status = ST_CROSS;
			end
		end
		CMD_SIZE: begin
			v = volume_at(r.sector);
			if (v < 0) begin
				o.status = ST_NO_VOLUME;
			end else begin
				o.volume_index = 3'(v);
				o.value = vol_size[v];
			end
		end
		CMD_CHECK: begin
			v = holder_of(r.sector);
			o.value = 32'(fake_on);
			if (v >= 0) begin
				o.volume_index = 3'(v);
				if (!vol_ro[v])
					o.value = 32'd1;
			end
		end
		default: o.status = ST_NO_VOLUME;
		endcase
		return o;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int pick;
		int i;
		bit [31:0] off;
		bit [31:0] room;
		r.command = CMD_READ;
		r.sector = $urandom();
		r.count = 16'($urandom());
		r.raw_size = $urandom();
		r.want_read_only = 1'($urandom());
		room = $urandom();
		pick = $urandom_range(99);
		if (pick < 8)
			r.command = CMD_ADD;
		else if (pick < 38)
			r.command = CMD_READ;
		else if (pick < 66)
			r.command = CMD_WRITE;
		else if (pick < 78)
			r.command = CMD_SIZE;
		else if (pick < 95)
			r.command = CMD_CHECK;
		else
			r.command = 3'($urandom_range(CMD_TOP, CMD_LAST + 1));

		if (r.command == CMD_ADD) begin
			case ($urandom_range(3))
			0: r.raw_size = $urandom_range(ROUND - 1);
			1: r.raw_size = $urandom();
			2: r.raw_size = $urandom_range(64, 1) * ROUND + $urandom_range(ROUND - 1);
			default: r.raw_size = $urandom() >> $urandom_range(31);
			endcase
		end else if (r.command == CMD_SIZE) begin
			if (vol_count > 0 && $urandom_range(3) != 0) begin
				i = $urandom_range(vol_count - 1);
				r.sector = vol_start[i] + 32'($urandom_range(3) == 0);
			end
		end else if (r.command <= CMD_LAST) begin
			if (vol_count > 0 && $urandom_range(3) != 0) begin
				i = $urandom_range(vol_count - 1);
				case ($urandom_range(4))
				0: off = '0;
				1: off = vol_size[i] - 1;
				2: off = vol_size[i];
				3: off = $urandom_range(vol_size[i] - 1);
				default: off = vol_size[i] - 32'($urandom_range(16, 1));
				endcase
				r.sector = vol_start[i] + off;
				room = vol_size[i] - off;
			end
			case ($urandom_range(3))
			0: r.count = 16'($urandom_range(15));
			1: r.count = 16'($urandom());
			2: begin
				if (room <= 32'hFFFF)
					r.count = 16'(room + 32'($urandom_range(1)));
			end
			default: r.count = $urandom_range(1) ? 16'hFFFF : 16'h0;
			endcase
		end
		return r;
	endfunction

	task automatic report(string msg);
		$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			vol_count = 0;
			run_end = '0;
			fake_on = 1'b0;
		end else begin
			if (cfg_we)
				fake_on = cfg_wdata;
			if (req_valid && !req_stall)
				owed_answers.push_back(map_request(req));
			if (!req_valid || !req_stall) begin
				if (queued_requests.size() != 0 && $urandom_range(99) >= offer_gap_pct) begin
					req <= queued_requests.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (owed_answers.size() == 0) begin
					report("result item with no request waiting");
				end else begin
					want = owed_answers.pop_front();
					if (rsp.status !== want.status)
						report($sformatf("status %0d, want %0d", rsp.status, want.status));
					if (rsp.volume_index !== want.volume_index)
						report($sformatf("volume_index %0d, want %0d",
							rsp.volume_index, want.volume_index));
					if (rsp.relative_sector !== want.relative_sector)
						report($sformatf("relative_sector %h, want %h",
							rsp.relative_sector, want.relative_sector));
					if (rsp.value !== want.value)
						report($sformatf("value %h, want %h", rsp.value, want.value));
				end
			end
			rsp_stall <= rsp_hold || ($urandom_range(99) < stall_pct);
		end
	end

	initial begin
		wait (squeeze_go);
		@(posedge clk);
		rsp_hold <= 1'b1;
		repeat (120) @(posedge clk);
		rsp_hold <= 1'b0;
	end

	initial begin
		#(12 * 400000);
		$display("sector_volume_map_top_test: errors");
		$finish;
	end

	task automatic offer(logic [2:0] cmd, logic [31:0] sec, logic [15:0] cnt,
			logic [31:0] raw, logic ro);
		req_t r;
		r.command = cmd;
		r.sector = sec;
		r.count = cnt;
		r.raw_size = raw;
		r.want_read_only = ro;
		queued_requests.push_back(r);
	endtask

	task automatic settle();
		while (queued_requests.size() != 0 || req_valid || owed_answers.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_write_bypass(logic v);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_burst(int n);
		repeat (n) begin
			while (queued_requests.size() >= 8)
				@(negedge clk);
			queued_requests.push_back(random_request());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_write_bypass(1'b0);
		offer(CMD_READ, 32'd0, 16'd1, 32'd0, 1'b0);
		offer(CMD_SIZE, 32'd0, 16'd0, 32'd0, 1'b0);
		offer(CMD_CHECK, 32'hFFFF_FFFF, 16'd0, 32'd0, 1'b0);
		offer(CMD_LAST + 3'd1, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		offer(CMD_TOP, 32'd0, 16'd0, 32'd0, 1'b0);
		offer(CMD_ADD, 32'd0, 16'd0, 32'd0, 1'b0);
		offer(CMD_ADD, 32'd0, 16'd0, 32'(ROUND - 1), 1'b1);
		offer(CMD_ADD, 32'd0, 16'd0, 32'd5000, 1'b0);
		offer(CMD_ADD, 32'd0, 16'd0, 32'(ROUND), 1'b1);
		offer(CMD_WRITE, 32'd4096, 16'd1, 32'd0, 1'b0);
		offer(CMD_WRITE, 32'd5119, 16'd5, 32'd0, 1'b0);
		offer(CMD_READ, 32'd5119, 16'd1, 32'd0, 1'b0);
		offer(CMD_READ, 32'd5119, 16'd2, 32'd0, 1'b0);
		offer(CMD_READ, 32'd0, 16'hFFFF, 32'd0, 1'b0);
		offer(CMD_WRITE, 32'd100, 16'd0, 32'd0, 1'b0);
		offer(CMD_SIZE, 32'd4096, 16'd0, 32'd0, 1'b0);
		offer(CMD_CHECK, 32'd4096, 16'd0, 32'd0, 1'b0);
		offer(CMD_CHECK, 32'd0, 16'd0, 32'd0, 1'b0);

		set_write_bypass(1'b1);
		offer(CMD_ADD, 32'd0, 16'd0, 32'h0010_07FF, 1'b1);
		offer(CMD_WRITE, 32'd4096, 16'hFFFF, 32'd0, 1'b0);
		offer(CMD_WRITE, 32'hFFFF_FFFF, 16'd3, 32'd0, 1'b0);
		offer(CMD_CHECK, 32'hFFFF_FFFF, 16'd0, 32'd0, 1'b0);
		offer(CMD_ADD, 32'd0, 16'd0, 32'hFFFF_FFFF, 1'b1);
		offer(CMD_READ, 32'h0010_1800, 16'd1, 32'd0, 1'b0);
		offer(CMD_CHECK, 32'd4096, 16'd0, 32'd0, 1'b0);

		set_write_bypass(1'b0);
		random_burst(412);

		set_write_bypass(1'b1);
		squeeze_go = 1'b1;
		random_burst(412);

		set_write_bypass(1'b0);
		offer_gap_pct = 0;
		stall_pct = 0;
		random_burst(250);
		offer_gap_pct = 35;
		stall_pct = 35;
		random_burst(162);

		set_write_bypass(1'b1);
		random_burst(412);

		settle();
		if (mismatches == 0)
			$display("sector_volume_map_top_test: clean");
		else
			$display("sector_volume_map_top_test: errors");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/svm_pkg.sv
src/svm_table.sv
src/svm_resolve.sv
src/sector_volume_map_top.sv
tb/sector_volume_map_top_test.sv
